[rtl/si_pkg.sv]
`timescale 1ns / 1ps

package si_pkg;

	// Default coordinate width (signed Q12.4 at 16 bits)
	localparam int COORD_WIDTH_DEF = 16;

	// Flags produced by the geometry front end, one set per item
	typedef struct packed {
		logic valid;
		logic den_zero;
		logic d_neg;
		logic s_neg;
		logic t_neg;
		logic s_zero;
		logic t_zero;
		logic x_neg;
		logic y_neg;
	} si_geo_t;

	// Control that travels with an item through the scale and divide stages
	typedef struct packed {
		logic valid;
		logic hit;
		logic par;
		logic x_neg;
		logic y_neg;
	} si_ctrl_t;

endpackage

[rtl/si_front.sv]
`timescale 1ns / 1ps

// Stages 1-4: deltas, cross products, denominator/numerators, magnitudes.
module si_front import si_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  logic signed [W-1:0] a_start_x,
	input  logic signed [W-1:0] a_start_y,
	input  logic signed [W-1:0] a_end_x,
	input  logic signed [W-1:0] a_end_y,
	input  logic signed [W-1:0] b_start_x,
	input  logic signed [W-1:0] b_start_y,
	input  logic signed [W-1:0] b_end_x,
	input  logic signed [W-1:0] b_end_y,
	output si_geo_t             geo_out,
	output logic [2*W:0]        sm_out,
	output logic [2*W:0]        tm_out,
	output logic [2*W:0]        dm_out,
	output logic [W-1:0]        dax_mag_out,
	output logic [W-1:0]        day_mag_out,
	output logic [W-1:0]        ax_out,
	output logic [W-1:0]        ay_out
);

	localparam int DW = W + 1;     // coordinate difference
	localparam int SW = 2 * W + 2; // signed product / sum
	localparam int MW = 2 * W + 1; // magnitude of a sum

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1;
	logic [W-1:0]         ax_s1, ay_s1;

	logic signed [SW-1:0] pd0_s2, pd1_s2, ps0_s2, ps1_s2, pt0_s2, pt1_s2;
	logic [W-1:0]         ax_s2, ay_s2, dax_mag_s2, day_mag_s2;
	logic                 x_neg_s2, y_neg_s2;

	logic signed [SW-1:0] den_s3, ns_s3, nt_s3;
	logic [W-1:0]         ax_s3, ay_s3, dax_mag_s3, day_mag_s3;
	logic                 x_neg_s3, y_neg_s3;

	logic [MW-1:0]        sm_s4, tm_s4, dm_s4;
	logic [W-1:0]         ax_s4, ay_s4, dax_mag_s4, day_mag_s4;
	logic                 x_neg_s4, y_neg_s4;
	logic                 den_zero_s4, d_neg_s4, s_neg_s4, t_neg_s4, s_zero_s4, t_zero_s4;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 1: sign-extended differences
	always_ff @(posedge clk) begin
		dax_s1 <= {a_end_x[W-1], a_end_x} - {a_start_x[W-1], a_start_x};
		day_s1 <= {a_end_y[W-1], a_end_y} - {a_start_y[W-1], a_start_y};
		dbx_s1 <= {b_end_x[W-1], b_end_x} - {b_start_x[W-1], b_start_x};
		dby_s1 <= {b_end_y[W-1], b_end_y} - {b_start_y[W-1], b_start_y};
		wx_s1  <= {b_start_x[W-1], b_start_x} - {a_start_x[W-1], a_start_x};
		wy_s1  <= {b_start_y[W-1], b_start_y} - {a_start_y[W-1], a_start_y};
		ax_s1  <= a_start_x;
		ay_s1  <= a_start_y;
	end

	// Stage 2: six signed products, direction magnitudes of A
	always_ff @(posedge clk) begin
		pd0_s2     <= dax_s1 * dby_s1;
		pd1_s2     <= day_s1 * dbx_s1;
		ps0_s2     <= wx_s1 * dby_s1;
		ps1_s2     <= wy_s1 * dbx_s1;
		pt0_s2     <= day_s1 * wx_s1;
		pt1_s2     <= dax_s1 * wy_s1;
		dax_mag_s2 <= dax_s1[DW-1] ? W'(-dax_s1) : dax_s1[W-1:0];
		day_mag_s2 <= day_s1[DW-1] ? W'(-day_s1) : day_s1[W-1:0];
		x_neg_s2   <= dax_s1[DW-1];
		y_neg_s2   <= day_s1[DW-1];
		ax_s2      <= ax_s1;
		ay_s2      <= ay_s1;
	end

	// Stage 3: denominator and both numerators
	always_ff @(posedge clk) begin
		den_s3     <= pd0_s2 - pd1_s2;
		ns_s3      <= ps0_s2 - ps1_s2;
		nt_s3      <= pt0_s2 - pt1_s2;
		dax_mag_s3 <= dax_mag_s2;
		day_mag_s3 <= day_mag_s2;
		x_neg_s3   <= x_neg_s2;
		y_neg_s3   <= y_neg_s2;
		ax_s3      <= ax_s2;
		ay_s3      <= ay_s2;
	end

	// Stage 4: signs, zero tests, magnitudes (|sum| < 2^(2W+1))
	always_ff @(posedge clk) begin
		dm_s4       <= den_s3[SW-1] ? MW'(-den_s3) : den_s3[MW-1:0];
		sm_s4       <= ns_s3[SW-1] ? MW'(-ns_s3) : ns_s3[MW-1:0];
		tm_s4       <= nt_s3[SW-1] ? MW'(-nt_s3) : nt_s3[MW-1:0];
		den_zero_s4 <= (den_s3 == '0);
		s_zero_s4   <= (ns_s3 == '0);
		t_zero_s4   <= (nt_s3 == '0);
		d_neg_s4    <= den_s3[SW-1];
		s_neg_s4    <= ns_s3[SW-1];
		t_neg_s4    <= nt_s3[SW-1];
		dax_mag_s4  <= dax_mag_s3;
		day_mag_s4  <= day_mag_s3;
		x_neg_s4    <= x_neg_s3;
		y_neg_s4    <= y_neg_s3;
		ax_s4       <= ax_s3;
		ay_s4       <= ay_s3;
	end

	assign geo_out.valid    = vld_s4;
	assign geo_out.den_zero = den_zero_s4;
	assign geo_out.d_neg    = d_neg_s4;
	assign geo_out.s_neg    = s_neg_s4;
	assign geo_out.t_neg    = t_neg_s4;
	assign geo_out.s_zero   = s_zero_s4;
	assign geo_out.t_zero   = t_zero_s4;
	assign geo_out.x_neg    = x_neg_s4;
	assign geo_out.y_neg    = y_neg_s4;
	assign sm_out           = sm_s4;
	assign tm_out           = tm_s4;
	assign dm_out           = dm_s4;
	assign dax_mag_out      = dax_mag_s4;
	assign day_mag_out      = day_mag_s4;
	assign ax_out           = ax_s4;
	assign ay_out           = ay_s4;

endmodule

[rtl/si_scale.sv]
`timescale 1ns / 1ps

// Stages 5-6: hit decision and |dA| * |num_s| as split partial products.
module si_scale import si_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  si_geo_t        geo_in,
	input  logic [2*W:0]   sm_in,
	input  logic [2*W:0]   tm_in,
	input  logic [2*W:0]   dm_in,
	input  logic [W-1:0]   dax_mag_in,
	input  logic [W-1:0]   day_mag_in,
	input  logic [W-1:0]   ax_in,
	input  logic [W-1:0]   ay_in,
	output si_ctrl_t       ctrl_out,
	output logic [3*W:0]   nx_out,
	output logic [3*W:0]   ny_out,
	output logic [2*W:0]   dm_out,
	output logic [W-1:0]   ax_out,
	output logic [W-1:0]   ay_out
);

	localparam int MW = 2 * W + 1;
	localparam int NW = 3 * W + 1;

	logic          in_s, in_t;
	si_ctrl_t      ctrl_s5, ctrl_s6;
	logic [2*W-1:0] xlo_s5, ylo_s5;
	logic [2*W:0]   xhi_s5, yhi_s5;
	logic [MW-1:0]  dm_s5, dm_s6;
	logic [W-1:0]   ax_s5, ay_s5, ax_s6, ay_s6;
	logic [NW-1:0]  nx_s6, ny_s6;

	// Parameter within [0,1]: zero, or same sign as den and not larger
	assign in_s = geo_in.s_zero || ((geo_in.s_neg == geo_in.d_neg) && (sm_in <= dm_in));
	assign in_t = geo_in.t_zero || ((geo_in.t_neg == geo_in.d_neg) && (tm_in <= dm_in));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
		end else begin
			ctrl_s5.valid <= geo_in.valid;
			ctrl_s5.hit   <= !geo_in.den_zero && in_s && in_t;
			ctrl_s5.par   <= geo_in.den_zero;
			ctrl_s5.x_neg <= geo_in.x_neg;
			ctrl_s5.y_neg <= geo_in.y_neg;
			ctrl_s6       <= ctrl_s5;
		end
	end

	// Stage 5: partial products on the low W and high W+1 bits of |num_s|
	always_ff @(posedge clk) begin
		xlo_s5 <= dax_mag_in * sm_in[W-1:0];
		xhi_s5 <= dax_mag_in * sm_in[MW-1:W];
		ylo_s5 <= day_mag_in * sm_in[W-1:0];
		yhi_s5 <= day_mag_in * sm_in[MW-1:W];
		dm_s5  <= dm_in;
		ax_s5  <= ax_in;
		ay_s5  <= ay_in;
	end

	// Stage 6: combine partial products
	always_ff @(posedge clk) begin
		nx_s6 <= NW'(xlo_s5) + {xhi_s5, {W{1'b0}}};
		ny_s6 <= NW'(ylo_s5) + {yhi_s5, {W{1'b0}}};
		dm_s6 <= dm_s5;
		ax_s6 <= ax_s5;
		ay_s6 <= ay_s5;
	end

	assign ctrl_out = ctrl_s6;
	assign nx_out   = nx_s6;
	assign ny_out   = ny_s6;
	assign dm_out   = dm_s6;
	assign ax_out   = ax_s6;
	assign ay_out   = ay_s6;

endmodule

[rtl/si_div_step.sv]
`timescale 1ns / 1ps

// One restoring-division step for both axes: quotient bit W-1-STEP.
module si_div_step import si_pkg::*; #(
	parameter int W    = COORD_WIDTH_DEF,
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  si_ctrl_t     ctrl_in,
	input  logic [3*W:0] rx_in,
	input  logic [3*W:0] ry_in,
	input  logic [2*W:0] d_in,
	input  logic [W-1:0] qx_in,
	input  logic [W-1:0] qy_in,
	input  logic [W-1:0] ax_in,
	input  logic [W-1:0] ay_in,
	output si_ctrl_t     ctrl_out,
	output logic [3*W:0] rx_out,
	output logic [3*W:0] ry_out,
	output logic [2*W:0] d_out,
	output logic [W-1:0] qx_out,
	output logic [W-1:0] qy_out,
	output logic [W-1:0] ax_out,
	output logic [W-1:0] ay_out
);

	localparam int NW  = 3 * W + 1;
	localparam int BIT = W - 1 - STEP;

	logic [NW-1:0] dsh;
	logic          ge_x, ge_y;
	logic [W-1:0]  qx_n, qy_n;
	si_ctrl_t      ctrl_q;
	logic [NW-1:0] rx_q, ry_q;
	logic [2*W:0]  d_q;
	logic [W-1:0]  qx_q, qy_q, ax_q, ay_q;

	// Trial subtract of the divisor aligned to this quotient bit
	assign dsh  = NW'(d_in) << BIT;
	assign ge_x = (rx_in >= dsh);
	assign ge_y = (ry_in >= dsh);

	always_comb begin
		qx_n      = qx_in;
		qy_n      = qy_in;
		qx_n[BIT] = ge_x;
		qy_n[BIT] = ge_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		rx_q <= ge_x ? rx_in - dsh : rx_in;
		ry_q <= ge_y ? ry_in - dsh : ry_in;
		d_q  <= d_in;
		qx_q <= qx_n;
		qy_q <= qy_n;
		ax_q <= ax_in;
		ay_q <= ay_in;
	end

	assign ctrl_out = ctrl_q;
	assign rx_out   = rx_q;
	assign ry_out   = ry_q;
	assign d_out    = d_q;
	assign qx_out   = qx_q;
	assign qy_out   = qy_q;
	assign ax_out   = ax_q;
	assign ay_out   = ay_q;

endmodule

[rtl/segment_intersection.sv]
`timescale 1ns / 1ps

// Channel | Handshake        | Signals
// --------+------------------+---------------------------------------------
// input   | start & !busy    | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
// result  | done (one cycle) | hit, parallel, cross_x, cross_y
//
// One segment pair per cycle; busy is always low since nothing stalls.
// The pipeline holds six front stages (deltas, products, sums, magnitudes,
// hit/partial products, product sum), one restoring division step per
// quotient bit, and the output register.
// Reset clears only the valid bits and control flags; in-flight transfers are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module segment_intersection import si_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_end_x,
	input  logic signed [COORD_WIDTH-1:0] a_end_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_end_x,
	input  logic signed [COORD_WIDTH-1:0] b_end_y,
	output logic                          done,
	output logic                          hit,
	output logic                          parallel,
	output logic signed [COORD_WIDTH-1:0] cross_x,
	output logic signed [COORD_WIDTH-1:0] cross_y
);

	localparam int W   = COORD_WIDTH;
	localparam int MW  = 2 * W + 1;
	localparam int NW  = 3 * W + 1;
	localparam int LAT = W + 7;

	si_geo_t       geo;
	logic [MW-1:0] sm, tm, dm_f;
	logic [W-1:0]  dax_mag, day_mag, ax_f, ay_f;

	si_ctrl_t      ctrl_c [0:W];
	logic [NW-1:0] rx_c   [0:W];
	logic [NW-1:0] ry_c   [0:W];
	logic [MW-1:0] d_c    [0:W];
	logic [W-1:0]  qx_c   [0:W];
	logic [W-1:0]  qy_c   [0:W];
	logic [W-1:0]  ax_c   [0:W];
	logic [W-1:0]  ay_c   [0:W];

	logic          done_q, hit_q, par_q;
	logic [W-1:0]  cx_q, cy_q;

	assign busy = 1'b0;

	// Geometry front end
	si_front #(.W(W)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_in      (start && !busy),
		.a_start_x   (a_start_x),
		.a_start_y   (a_start_y),
		.a_end_x     (a_end_x),
		.a_end_y     (a_end_y),
		.b_start_x   (b_start_x),
		.b_start_y   (b_start_y),
		.b_end_x     (b_end_x),
		.b_end_y     (b_end_y),
		.geo_out     (geo),
		.sm_out      (sm),
		.tm_out      (tm),
		.dm_out      (dm_f),
		.dax_mag_out (dax_mag),
		.day_mag_out (day_mag),
		.ax_out      (ax_f),
		.ay_out      (ay_f)
	);

	// Hit test and dividend
	si_scale #(.W(W)) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.geo_in     (geo),
		.sm_in      (sm),
		.tm_in      (tm),
		.dm_in      (dm_f),
		.dax_mag_in (dax_mag),
		.day_mag_in (day_mag),
		.ax_in      (ax_f),
		.ay_in      (ay_f),
		.ctrl_out   (ctrl_c[0]),
		.nx_out     (rx_c[0]),
		.ny_out     (ry_c[0]),
		.dm_out     (d_c[0]),
		.ax_out     (ax_c[0]),
		.ay_out     (ay_c[0])
	);

	assign qx_c[0] = '0;
	assign qy_c[0] = '0;

	// Divider chain, one quotient bit per stage (quotient <= |dA| < 2^W on a hit)
	for (genvar k = 0; k < W; k++) begin : g_div
		si_div_step #(.W(W), .STEP(k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_in  (ctrl_c[k]),
			.rx_in    (rx_c[k]),
			.ry_in    (ry_c[k]),
			.d_in     (d_c[k]),
			.qx_in    (qx_c[k]),
			.qy_in    (qy_c[k]),
			.ax_in    (ax_c[k]),
			.ay_in    (ay_c[k]),
			.ctrl_out (ctrl_c[k+1]),
			.rx_out   (rx_c[k+1]),
			.ry_out   (ry_c[k+1]),
			.d_out    (d_c[k+1]),
			.qx_out   (qx_c[k+1]),
			.qy_out   (qy_c[k+1]),
			.ax_out   (ax_c[k+1]),
			.ay_out   (ay_c[k+1])
		);
	end

	// Output register: strobe and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			par_q  <= 1'b0;
		end else begin
			done_q <= ctrl_c[W].valid;
			hit_q  <= ctrl_c[W].valid && ctrl_c[W].hit;
			par_q  <= ctrl_c[W].valid && ctrl_c[W].par;
		end
	end

	// Point = A.start +/- quotient, zero without a hit
	always_ff @(posedge clk) begin
		if (ctrl_c[W].hit) begin
			cx_q <= ctrl_c[W].x_neg ? ax_c[W] - qx_c[W] : ax_c[W] + qx_c[W];
			cy_q <= ctrl_c[W].y_neg ? ay_c[W] - qy_c[W] : ay_c[W] + qy_c[W];
		end else begin
			cx_q <= '0;
			cy_q <= '0;
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign parallel = par_q;
	assign cross_x  = cx_q;
	assign cross_y  = cy_q;

	// Every accepted pair yields exactly one strobe
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted pair produced no result");

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transfer");

	// A parallel pair can never be reported as a hit
	a_hit_not_par: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && parallel))
		else $error("hit and parallel both set");

	// The point stays zero whenever there is no hit
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (cross_x == '0 && cross_y == '0))
		else $error("nonzero point without a hit");

endmodule

[dv/si_checker.sv]
`timescale 1ns / 1ps

// Watches the pair and result channels of segment_intersection, predicts each
// result from the accepted pair and compares it in order.
module si_checker import si_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic signed [W-1:0] a_start_x,
	input  logic signed [W-1:0] a_start_y,
	input  logic signed [W-1:0] a_end_x,
	input  logic signed [W-1:0] a_end_y,
	input  logic signed [W-1:0] b_start_x,
	input  logic signed [W-1:0] b_start_y,
	input  logic signed [W-1:0] b_end_x,
	input  logic signed [W-1:0] b_end_y,
	input  logic                done,
	input  logic                hit,
	input  logic                parallel,
	input  logic signed [W-1:0] cross_x,
	input  logic signed [W-1:0] cross_y,
	output int                  mismatches,
	output int                  outstanding
);

	typedef logic signed [W-1:0] coord_t;

	typedef struct packed {
		logic   hit;
		logic   parallel;
		coord_t x;
		coord_t y;
	} crossing_t;

	crossing_t crossings_due[$];
	int        fail_count = 0;

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// num/den lies in [0,1]; den is nonzero
	function automatic bit in_unit(input longint num, input longint den);
		if (num == 0)
			return 1'b1;
		if ((num < 0) != (den < 0))
			return 1'b0;
		return mag(num) <= mag(den);
	endfunction

	// origin + delta*num_s/den, quotient truncated toward zero
	function automatic coord_t along_a(input longint origin, input longint delta,
			input longint num_s, input longint den);
		longint q;
		longint pt;
		q  = mag(num_s) * mag(delta) / mag(den);
		pt = delta < 0 ? origin - q : origin + q;
		return pt[W-1:0];
	endfunction

	// Exact integer intersection of segments A and B
	function automatic crossing_t predict_crossing(input coord_t asx, input coord_t asy,
			input coord_t aex, input coord_t aey, input coord_t bsx, input coord_t bsy,
			input coord_t bex, input coord_t bey);
		longint    dax, day, dbx, dby, wx, wy;
		longint    den, num_s, num_t;
		crossing_t r;
		dax   = longint'(aex) - longint'(asx);
		day   = longint'(aey) - longint'(asy);
		dbx   = longint'(bex) - longint'(bsx);
		dby   = longint'(bey) - longint'(bsy);
		wx    = longint'(bsx) - longint'(asx);
		wy    = longint'(bsy) - longint'(asy);
		den   = dax * dby - day * dbx;
		num_s = wx * dby - wy * dbx;
		num_t = day * wx - dax * wy;
		r = '0;
		if (den == 0) begin
			r.parallel = 1'b1;
		end else if (in_unit(num_s, den) && in_unit(num_t, den)) begin
			r.hit = 1'b1;
			r.x   = along_a(asx, dax, num_s, den);
			r.y   = along_a(asy, day, num_s, den);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [W-1:0] want,
			input logic signed [W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Retire results against the oldest prediction, then queue the new pair
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			if (done) begin
				if (crossings_due.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, actual hit=%0b parallel=%0b x=%0d y=%0d",
						$time, hit, parallel, cross_x, cross_y);
				end else begin
					want = crossings_due.pop_front();
					check_field("hit", want.hit, hit);
					check_field("parallel", want.parallel, parallel);
					check_field("cross_x", want.x, cross_x);
					check_field("cross_y", want.y, cross_y);
				end
			end
			if (start && !busy)
				crossings_due.push_back(predict_crossing(a_start_x, a_start_y, a_end_x,
					a_end_y, b_start_x, b_start_y, b_end_x, b_end_y));
		end
		mismatches  <= fail_count;
		outstanding <= crossings_due.size();
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import si_pkg::*;

	localparam int W           = COORD_WIDTH_DEF;
	localparam int N_RANDOM    = 1400;
	localparam int QUIET_TAIL  = 200;
	localparam int LATENCY     = W + 7;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {
		PAIR_WILD,
		PAIR_LOCAL,
		PAIR_THROUGH,
		PAIR_PARALLEL,
		PAIR_POINT,
		PAIR_JOINED
	} pair_kind_e;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic signed [W-1:0] a_start_x = '0;
	logic signed [W-1:0] a_start_y = '0;
	logic signed [W-1:0] a_end_x   = '0;
	logic signed [W-1:0] a_end_y   = '0;
	logic signed [W-1:0] b_start_x = '0;
	logic signed [W-1:0] b_start_y = '0;
	logic signed [W-1:0] b_end_x   = '0;
	logic signed [W-1:0] b_end_y   = '0;
	logic                busy;
	logic                done;
	logic                hit;
	logic                parallel;
	logic signed [W-1:0] cross_x;
	logic signed [W-1:0] cross_y;
	int                  mismatches;
	int                  outstanding;
	int                  cycles = 0;

	segment_intersection #(.COORD_WIDTH(W)) dut (.*);

	si_checker #(.W(W)) crossing_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int rnd_span(input int r);
		return int'($urandom_range(2 * r, 0)) - r;
	endfunction

	// One pair transfer; start stays high so back-to-back pairs need no gap
	task automatic send_pair(input int asx, input int asy, input int aex, input int aey,
			input int bsx, input int bsy, input int bex, input int bey);
		start     <= 1'b1;
		a_start_x <= asx[W-1:0];
		a_start_y <= asy[W-1:0];
		a_end_x   <= aex[W-1:0];
		a_end_y   <= aey[W-1:0];
		b_start_x <= bsx[W-1:0];
		b_start_y <= bsy[W-1:0];
		b_end_x   <= bex[W-1:0];
		b_end_y   <= bey[W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_pair();
		int         r, k, m0, m1;
		int         x0, y0, x1, y1, ux, uy, px, py, ox, oy;
		pair_kind_e kind;
		r = $urandom_range(9, 0);
		if (r <= 2)      kind = PAIR_WILD;
		else if (r == 3) kind = PAIR_LOCAL;
		else if (r <= 6) kind = PAIR_THROUGH;
		else if (r == 7) kind = PAIR_PARALLEL;
		else if (r == 8) kind = PAIR_POINT;
		else             kind = PAIR_JOINED;
		case (kind)
			PAIR_WILD: begin
				send_pair($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end
			PAIR_LOCAL: begin
				ox = rnd_span(32600);
				oy = rnd_span(32600);
				send_pair(ox + rnd_span(64), oy + rnd_span(64), ox + rnd_span(64),
					oy + rnd_span(64), ox + rnd_span(64), oy + rnd_span(64),
					ox + rnd_span(64), oy + rnd_span(64));
			end
			PAIR_THROUGH: begin
				// One segment crosses the other's line near a point on it, endpoints included
				x0 = rnd_span(8000);
				y0 = rnd_span(8000);
				x1 = rnd_span(8000);
				y1 = rnd_span(8000);
				k  = $urandom_range(16, 0);
				px = x0 + (x1 - x0) * k / 16;
				py = y0 + (y1 - y0) * k / 16;
				ux = rnd_span(2000);
				uy = rnd_span(2000);
				m0 = $urandom_range(3, 0);
				m1 = $urandom_range(3, 0);
				if ($urandom_range(1, 0))
					send_pair(x0, y0, x1, y1, px - ux * m0, py - uy * m0,
						px + ux * m1, py + uy * m1);
				else
					send_pair(px - ux * m0, py - uy * m0, px + ux * m1, py + uy * m1,
						x0, y0, x1, y1);
			end
			PAIR_PARALLEL: begin
				// parallel directions; collinear when there is no offset
				x0 = rnd_span(16000);
				y0 = rnd_span(16000);
				ux = rnd_span(300);
				uy = rnd_span(300);
				k  = $urandom_range(3, 1);
				m0 = rnd_span(40);
				m1 = rnd_span(3);
				ox = $urandom_range(1, 0) ? rnd_span(50) : 0;
				oy = $urandom_range(1, 0) ? rnd_span(50) : 0;
				px = x0 + ux * m0 + ox;
				py = y0 + uy * m0 + oy;
				send_pair(x0, y0, x0 + ux * k, y0 + uy * k, px, py,
					px + ux * m1, py + uy * m1);
			end
			PAIR_POINT: begin
				x0 = rnd_span(16000);
				y0 = rnd_span(16000);
				x1 = rnd_span(16000);
				y1 = rnd_span(16000);
				if ($urandom_range(1, 0)) begin
					k  = $urandom_range(16, 0);
					px = x0 + (x1 - x0) * k / 16;
					py = y0 + (y1 - y0) * k / 16;
				end else begin
					px = rnd_span(16000);
					py = rnd_span(16000);
				end
				if ($urandom_range(1, 0))
					send_pair(x0, y0, x1, y1, px, py, px, py);
				else
					send_pair(px, py, px, py, x0, y0, x1, y1);
			end
			default: begin
				// B starts on an end of A
				x0 = rnd_span(16000);
				y0 = rnd_span(16000);
				x1 = rnd_span(16000);
				y1 = rnd_span(16000);
				px = $urandom_range(1, 0) ? x0 : x1;
				py = (px == x0) ? y0 : y1;
				send_pair(x0, y0, x1, y1, px, py, rnd_span(16000), rnd_span(16000));
			end
		endcase
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);                      // both degenerate
		send_pair(-160, 0, 160, 0, 0, -160, 0, 160);            // plain cross
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_pair(0, 0, 100, 0, 100, 0, 100, 50);               // touch at A end, B start
		send_pair(0, 0, 100, 0, 0, -50, 0, 50);                 // touch at A start
		send_pair(0, 0, 100, 0, 100, -100, 100, 0);             // both ends meet
		send_pair(0, 0, 100, 0, 101, -5, 101, 5);               // just past A end
		send_pair(0, 0, 100, 0, 50, 1, 50, 60);                 // beyond B start
		send_pair(0, 0, 100, 0, -1, -5, -1, 5);                 // behind A start
		send_pair(0, 0, 100, 100, 0, 10, 100, 110);             // parallel apart
		send_pair(0, 0, 100, 100, 50, 50, 150, 150);            // collinear overlap
		send_pair(0, 0, 100, 100, 50, 50, 50, 50);              // point on A
		send_pair(-160, 0, 160, 0, 0, 160, 0, -160);            // negative denominator
		send_pair(10, 10, -7, 3, 0, -20, 3, 30);                // truncation, negative deltas
		send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
		send_pair(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);                  // crossing at origin
		send_pair(0, 0, 3, 7, 3, 0, 0, 7);
		drain();

		// Random pairs with bursty gaps; the tail runs at full rate
		for (int i = 0; i < N_RANDOM; i++) begin
			random_pair();
			if (i == N_RANDOM / 2)
				drain();
			else if (i < N_RANDOM - QUIET_TAIL && (i / 100) % 4 != 0 &&
					$urandom_range(3, 0) == 0)
				pause($urandom_range(17, 1));
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[segment_intersection.f]
rtl/si_pkg.sv
rtl/si_front.sv
rtl/si_scale.sv
rtl/si_div_step.sv
rtl/segment_intersection.sv
dv/si_checker.sv
dv/tb.sv
